// ===== hdl/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ILS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ILS_ASSERT(lbl, prop, msg)
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/ils_pkg.sv =====
package ils_pkg;

	localparam int DEPTH = 64;
	localparam int WIDTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_ERASE  = 3'd3,
		CMD_RANGE  = 3'd4,
		CMD_RESIZE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic             we;
		logic [AW-1:0]    waddr;
		logic [WIDTH-1:0] wdata;
		logic             re;
		logic [AW-1:0]    raddr;
	} ram_req_t;

endpackage

// ===== hdl/ils_ram.sv =====
module ils_ram (
	input  logic                     clk,
	input  ils_pkg::ram_req_t        req,
	output logic [ils_pkg::WIDTH-1:0] rdata
);
	import ils_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== hdl/indexed_list_store.sv =====
// Bounded ordered list of DEPTH elements held in a single-port-write RAM.
// A command is taken when start is high and busy is low; its one result
// shows on status, popped_value and length for exactly one cycle with done
// high, and the receiver cannot stall it. Push, resize and every refused or
// ignored command answer on the cycle after acceptance; pop answers from
// S_POP, which registers the RAM read data. Insert, erase and erase-range
// move the later elements one per cycle through the RAM (read then write
// back one slot over) in S_SHIFT, and answer once the last write has
// retired. busy stays high for the whole move. The RAM has no reset;
// reset clears the length and the control state.
module indexed_list_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [6:0]  position,
	input  logic [5:0]  end_position,
	input  logic [63:0] element_value,
	input  logic [6:0]  new_length,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] popped_value,
	output logic [6:0]  length
);
	import ils_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SHIFT
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    moves_q;
	logic [AW-1:0]    rd_q;
	logic [AW-1:0]    wa_q;
	logic             wpend_q;
	logic             down_q;
	logic             ins_q;
	logic [AW-1:0]    pos_q;
	logic [WIDTH-1:0] val_q;
	logic             done_q;
	status_t          status_q;
	logic [63:0]      popped_q;
	logic [CW-1:0]    length_q;

	ram_req_t         req;
	logic [WIDTH-1:0] rdata;

	logic             accept;
	logic [31:0]      cnt32, pos32, last32, len32;
	logic             not_full, do_push, do_pop, do_ins, do_erase, do_range;
	logic             shift_end;

	ils_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign cnt32  = 32'(count_q);
	assign pos32  = 32'(position);
	assign last32 = 32'(end_position);
	assign len32  = 32'(new_length);

	assign not_full = (cnt32 < DEPTH);
	assign do_push  = not_full && ((cmd_t'(cmd) == CMD_PUSH) ||
	                  ((cmd_t'(cmd) == CMD_INSERT) && (pos32 == cnt32)));
	assign do_pop   = (cmd_t'(cmd) == CMD_POP) && (count_q != '0);
	assign do_ins   = (cmd_t'(cmd) == CMD_INSERT) && (pos32 < cnt32) && not_full;
	assign do_erase = (cmd_t'(cmd) == CMD_ERASE) && (pos32 < cnt32);
	assign do_range = (cmd_t'(cmd) == CMD_RANGE) && (pos32 <= last32) &&
	                  (last32 < cnt32);

	assign shift_end = (moves_q == '0) && !wpend_q;

	always_comb begin
		req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && do_push) begin
					req.we    = 1'b1;
					req.waddr = count_q[AW-1:0];
					req.wdata = element_value[WIDTH-1:0];
				end
				if (accept && do_pop) begin
					req.re    = 1'b1;
					req.raddr = AW'(count_q - CW'(1));
				end
			end
			S_SHIFT: begin
				req.re    = (moves_q != '0);
				req.raddr = rd_q;
				if (wpend_q) begin
					req.we    = 1'b1;
					req.waddr = wa_q;
					req.wdata = rdata;
				end else if (shift_end && ins_q) begin
					req.we    = 1'b1;
					req.waddr = pos_q;
					req.wdata = val_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			moves_q  <= '0;
			wpend_q  <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
			length_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_DONE;
						popped_q <= '0;
						length_q <= count_q;
						done_q   <= 1'b1;
						wpend_q  <= 1'b0;
						pos_q    <= position[AW-1:0];
						val_q    <= element_value[WIDTH-1:0];
						case (cmd_t'(cmd))
							CMD_PUSH: begin
								if (do_push) begin
									count_q  <= count_q + CW'(1);
									length_q <= count_q + CW'(1);
								end else begin
									status_q <= ST_FULL;
								end
							end
							CMD_POP: begin
								if (do_pop) begin
									count_q <= count_q - CW'(1);
									done_q  <= 1'b0;
									state_q <= S_POP;
								end else begin
									status_q <= ST_EMPTY;
								end
							end
							CMD_INSERT: begin
								if (do_push) begin
									count_q  <= count_q + CW'(1);
									length_q <= count_q + CW'(1);
								end else if (pos32 > cnt32) begin
									status_q <= ST_BAD;
								end else if (!do_ins) begin
									status_q <= ST_FULL;
								end else begin
									// move count-pos elements up, top first
									moves_q <= CW'(cnt32 - pos32);
									rd_q    <= AW'(count_q - CW'(1));
									wa_q    <= count_q[AW-1:0];
									down_q  <= 1'b1;
									ins_q   <= 1'b1;
									count_q <= count_q + CW'(1);
									done_q  <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							CMD_ERASE: begin
								if (do_erase) begin
									moves_q <= CW'(cnt32 - pos32 - 32'd1);
									rd_q    <= AW'(pos32 + 32'd1);
									wa_q    <= position[AW-1:0];
									down_q  <= 1'b0;
									ins_q   <= 1'b0;
									count_q <= count_q - CW'(1);
									done_q  <= 1'b0;
									state_q <= S_SHIFT;
								end else begin
									status_q <= ST_BAD;
								end
							end
							CMD_RANGE: begin
								if (do_range) begin
									moves_q <= CW'(cnt32 - last32 - 32'd1);
									rd_q    <= AW'(last32 + 32'd1);
									wa_q    <= position[AW-1:0];
									down_q  <= 1'b0;
									ins_q   <= 1'b0;
									count_q <= CW'(cnt32 - last32 - 32'd1 + pos32);
									done_q  <= 1'b0;
									state_q <= S_SHIFT;
								end else begin
									status_q <= ST_BAD;
								end
							end
							CMD_RESIZE: begin
								if (len32 > DEPTH) begin
									status_q <= ST_FULL;
								end else begin
									count_q  <= CW'(new_length);
									length_q <= CW'(new_length);
								end
							end
							default: begin
								status_q <= ST_BAD;
							end
						endcase
					end
				end
				S_POP: begin
					popped_q <= 64'(rdata);
					length_q <= count_q;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_SHIFT: begin
					// retire the pending write, then issue the next read
					if (wpend_q) begin
						wa_q <= down_q ? wa_q - AW'(1) : wa_q + AW'(1);
					end
					if (moves_q != '0) begin
						rd_q    <= down_q ? rd_q - AW'(1) : rd_q + AW'(1);
						moves_q <= moves_q - CW'(1);
						wpend_q <= 1'b1;
					end else begin
						wpend_q <= 1'b0;
					end
					if (shift_end) begin
						length_q <= count_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign length       = 7'(length_q);

`include "assert_macros.svh"

	`ILS_ASSERT(a_count_bound, (32'(count_q) <= DEPTH), "element count above DEPTH")
	`ILS_ASSERT(a_no_done_busy, (!(busy && done_q)), "result strobe while busy")
	`ILS_ASSERT_NEXT(a_accept_moves, accept, (busy || done_q), "command dropped")
	`ILS_ASSERT(a_pop_zero, (!(done_q && (status_q != ST_DONE)) || (popped_q == '0)),
		"nonzero popped value on refused command")

endmodule

// ===== test/indexed_list_store_test.sv =====
`timescale 1ns / 100ps

import ils_pkg::*;

class list_scoreboard;
	typedef struct {
		status_t     status;
		logic [63:0] popped;
		logic [6:0]  length;
	} answer_t;

	logic [WIDTH-1:0] store [DEPTH];
	bit               written [DEPTH];
	int               count;
	answer_t          pending [$];
	int               errors;
	int               commands;
	int               checked;
	int               longest;
	int               seen [4];

	function new();
		count = 0;
		errors = 0;
		commands = 0;
		checked = 0;
		longest = 0;
		foreach (written[k]) written[k] = 0;
		foreach (seen[k]) seen[k] = 0;
	endfunction

	function status_t append(logic [63:0] val);
		if (count >= DEPTH)
			return ST_FULL;
		store[count] = val[WIDTH-1:0];
		written[count] = 1;
		count++;
		return ST_DONE;
	endfunction

	// Work out the answer to one accepted command and queue it.
	function void note(logic [2:0] op, logic [6:0] pos, logic [5:0] last_pos,
			logic [63:0] val, logic [6:0] req_len);
		answer_t a;
		int      dst;
		a.status = ST_DONE;
		a.popped = '0;
		case (op)
			CMD_PUSH: a.status = append(val);
			CMD_POP: begin
				if (count == 0) begin
					a.status = ST_EMPTY;
				end else begin
					count--;
					a.popped = 64'(store[count]);
				end
			end
			CMD_INSERT: begin
				if (pos == count) begin
					a.status = append(val);
				end else if (pos > count) begin
					a.status = ST_BAD;
				end else if (count >= DEPTH) begin
					a.status = ST_FULL;
				end else begin
					for (int k = count; k > pos; k--) begin
						store[k] = store[k-1];
						written[k] = written[k-1];
					end
					store[pos] = val[WIDTH-1:0];
					written[pos] = 1;
					count++;
				end
			end
			CMD_ERASE: begin
				if (pos < count) begin
					for (int k = pos; k + 1 < count; k++) begin
						store[k] = store[k+1];
						written[k] = written[k+1];
					end
					count--;
				end else begin
					a.status = ST_BAD;
				end
			end
			CMD_RANGE: begin
				if (pos <= last_pos && pos < count && last_pos < count) begin
					dst = pos;
					for (int k = last_pos + 1; k < count; k++) begin
						store[dst] = store[k];
						written[dst] = written[k];
						dst++;
					end
					count -= last_pos - pos + 1;
				end else begin
					a.status = ST_BAD;
				end
			end
			CMD_RESIZE: begin
				if (req_len > DEPTH)
					a.status = ST_FULL;
				else
					count = req_len;
			end
			default: a.status = ST_BAD;
		endcase
		a.length = 7'(count);
		if (count > longest)
			longest = count;
		seen[a.status]++;
		commands++;
		pending.push_back(a);
	endfunction

	function void check(logic [1:0] status, logic [63:0] popped, logic [6:0] length);
		answer_t a;
		if (pending.size() == 0) begin
			$display("%0t: result with nothing expected: status %0d popped %h length %0d",
				$time, status, popped, length);
			errors++;
			return;
		end
		a = pending.pop_front();
		checked++;
		if (status !== a.status) begin
			$display("%0t: status mismatch: expected %0d actual %0d", $time, a.status, status);
			errors++;
		end
		if (popped !== a.popped) begin
			$display("%0t: popped_value mismatch: expected %h actual %h",
				$time, a.popped, popped);
			errors++;
		end
		if (length !== a.length) begin
			$display("%0t: length mismatch: expected %0d actual %0d", $time, a.length, length);
			errors++;
		end
	endfunction
endclass

module indexed_list_store_test;
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam int RANDOM_PER_PHASE = 385;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [6:0]  position;
	logic [5:0]  end_position;
	logic [63:0] element_value;
	logic [6:0]  new_length;
	logic        done;
	logic [1:0]  status;
	logic [63:0] popped_value;
	logic [6:0]  length;

	list_scoreboard sb;
	int idle_pct;
	bit grow;

	indexed_list_store uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.position(position),
		.end_position(end_position),
		.element_value(element_value),
		.new_length(new_length),
		.done(done),
		.status(status),
		.popped_value(popped_value),
		.length(length)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check(status, popped_value, length);
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic issue(input logic [2:0] op, input logic [6:0] pos,
			input logic [5:0] last_pos, input logic [63:0] val, input logic [6:0] req_len);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		cmd = op;
		position = pos;
		end_position = last_pos;
		element_value = val;
		new_length = req_len;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note(op, pos, last_pos, val, req_len);
		@(negedge clk);
	endtask

	task automatic random_item();
		logic [2:0]  op;
		logic [6:0]  pos;
		logic [5:0]  last_pos;
		logic [63:0] val;
		logic [6:0]  req_len;
		int          w [7];
		int          roll;
		int          len;
		int          a;
		int          b;
		len = sb.count;
		pos = 7'($urandom_range(127));
		last_pos = 6'($urandom_range(63));
		val = {$urandom, $urandom};
		req_len = 7'($urandom_range(127));
		if ($urandom_range(15) == 0)
			val = $urandom_range(1) ? '1 : '0;
		if (grow)
			w = '{30, 8, 27, 12, 6, 7, 2};
		else
			w = '{10, 25, 12, 22, 16, 13, 2};
		roll = $urandom_range(99);
		op = CMD_UNUSED_LO;
		for (int k = 0; k < 6; k++) begin
			if (roll < w[k]) begin
				op = 3'(k);
				break;
			end
			roll -= w[k];
		end
		if (op == CMD_UNUSED_LO && $urandom_range(1))
			op = CMD_UNUSED_HI;
		// a pop must never read an entry that resize exposed unwritten
		if (op == CMD_POP && len > 0 && !sb.written[len-1])
			op = CMD_PUSH;
		case (op)
			CMD_INSERT: if ($urandom_range(99) < 85) pos = 7'($urandom_range(len));
			CMD_ERASE: if (len > 0 && $urandom_range(99) < 85) pos = 7'($urandom_range(len - 1));
			CMD_RANGE: begin
				if (len > 0 && $urandom_range(99) < 85) begin
					a = $urandom_range(len - 1);
					b = $urandom_range(3) == 0 ? len - 1 : $urandom_range(len - 1);
					pos = 7'(a < b ? a : b);
					last_pos = 6'(a < b ? b : a);
				end
			end
			CMD_RESIZE: if ($urandom_range(99) < 80) req_len = 7'($urandom_range(DEPTH));
			default: ;
		endcase
		issue(op, pos, last_pos, val, req_len);
		if (sb.count >= DEPTH - 4)
			grow = 0;
		else if (sb.count <= 2)
			grow = 1;
		else if ($urandom_range(199) == 0)
			grow = ~grow;
	endtask

	initial begin
		int phase_idle [4];
		int guard;
		phase_idle = '{0, 86, 0, 36};
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_PUSH;
		position = '0;
		end_position = '0;
		element_value = '0;
		new_length = '0;
		idle_pct = 0;
		grow = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list, bad positions, then shifting and truncation
		issue(CMD_POP, 0, 0, 64'h0, 0);
		issue(CMD_ERASE, 0, 0, 64'h0, 0);
		issue(CMD_RANGE, 0, 0, 64'h0, 0);
		issue(CMD_INSERT, 1, 0, 64'h0, 0);
		issue(CMD_INSERT, 0, 0, '1, 0);
		issue(CMD_PUSH, 0, 0, 64'h0, 0);
		issue(CMD_PUSH, 0, 0, 64'hA5A5_5A5A_A5A5_5A5A, 0);
		issue(CMD_INSERT, 0, 0, 64'h0123_4567_89AB_CDEF, 0);
		issue(CMD_INSERT, 2, 0, 64'h8000_0000_0000_0001, 0);
		issue(CMD_ERASE, 0, 0, 64'h0, 0);
		issue(CMD_ERASE, 4, 0, 64'h0, 0);
		issue(CMD_RANGE, 0, 0, 64'h0, 0);
		issue(CMD_RANGE, 2, 1, 64'h0, 0);
		issue(CMD_RANGE, 1, 3, 64'h0, 0);
		issue(CMD_RANGE, 1, 2, 64'h0, 0);
		issue(CMD_POP, 0, 0, 64'h0, 0);
		// capacity limits
		issue(CMD_RESIZE, 0, 0, 64'h0, 7'(DEPTH + 1));
		issue(CMD_RESIZE, 0, 0, 64'h0, 127);
		issue(CMD_RESIZE, 0, 0, 64'h0, 7'(DEPTH));
		issue(CMD_PUSH, 0, 0, '1, 0);
		issue(CMD_INSERT, 0, 0, '1, 0);
		issue(CMD_INSERT, 7'(DEPTH), 0, '1, 0);
		issue(CMD_INSERT, 127, 63, '1, 127);
		issue(CMD_UNUSED_LO, 0, 0, 64'h0, 0);
		issue(CMD_UNUSED_HI, 127, 63, '1, 127);
		issue(CMD_ERASE, 0, 0, 64'h0, 0);
		issue(CMD_RANGE, 0, 6'(DEPTH - 2), 64'h0, 0);

		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				random_item();
		end
		start = 1'b0;

		guard = 0;
		while (sb.pending.size() > 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DEPTH + 8) @(posedge clk);
		if (sb.pending.size() > 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		$display("%0d commands sent, %0d answers checked; longest list %0d",
			sb.commands, sb.checked, sb.longest);
		$display("answers: %0d done, %0d empty, %0d full, %0d bad index",
			sb.seen[ST_DONE], sb.seen[ST_EMPTY], sb.seen[ST_FULL], sb.seen[ST_BAD]);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
